// ===== rtl/lda_pkg.sv =====
package lda_pkg;

	// Grid and count geometry.
	localparam int GRID_WIDTH  = 256;
	localparam int GRID_HEIGHT = 256;
	localparam int COUNT_BITS  = 16;

	localparam int CELL_TOTAL = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_BITS  = $clog2(CELL_TOTAL);
	localparam int ROW_BITS   = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
	localparam int COORD_BITS = 8;
	localparam int CMP_BITS   = 14;
	localparam int ERR_BITS   = 11;
	localparam int VALUE_BITS = 16;

	localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(CELL_TOTAL - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Item kinds.
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_DRAW  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_BOOT_CLEAR,
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_READ,
		ST_FINISH
	} st_t;

	// Segment endpoints handed to the walker.
	typedef struct packed {
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
	} seg_t;

	// One visited pixel from the walker.
	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} pix_t;

	// True when the pixel lies inside the grid.
	function automatic logic on_grid(input logic [COORD_BITS-1:0] x,
			input logic [COORD_BITS-1:0] y);
		return (CMP_BITS'(x) < CMP_BITS'(GRID_WIDTH)) &&
			(CMP_BITS'(y) < CMP_BITS'(GRID_HEIGHT));
	endfunction

	// Store address of a pixel: row GRID_HEIGHT-1-y, column x.
	function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [COORD_BITS-1:0] x,
			input logic [COORD_BITS-1:0] y);
		logic [ROW_BITS-1:0] row;
		row = ROW_BITS'(GRID_HEIGHT - 1) - ROW_BITS'(y);
		return ADDR_BITS'(row) * ADDR_BITS'(GRID_WIDTH) + ADDR_BITS'(x);
	endfunction

	// Saturating increment of a count.
	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
	endfunction

	// Count clipped to the width of the result field.
	function automatic logic [VALUE_BITS-1:0] clip_value(input logic [COUNT_BITS-1:0] c);
		return (32'(c) > 32'hFFFF) ? {VALUE_BITS{1'b1}} : VALUE_BITS'(c);
	endfunction

endpackage

// ===== rtl/lda_count_mem.sv =====
module lda_count_mem (
	input  logic                           clk,
	input  logic                           we,
	input  logic [lda_pkg::ADDR_BITS-1:0]  waddr,
	input  logic [lda_pkg::COUNT_BITS-1:0] wdata,
	input  logic                           re,
	input  logic [lda_pkg::ADDR_BITS-1:0]  raddr,
	output logic [lda_pkg::COUNT_BITS-1:0] rdata
);
	import lda_pkg::*;

	logic [COUNT_BITS-1:0] mem_q [CELL_TOTAL];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/lda_walker.sv =====
module lda_walker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lda_pkg::seg_t seg,
	output lda_pkg::pix_t pix
);
	import lda_pkg::*;

	logic                       busy_q;
	logic                       steep_q;
	logic                       neg_q;
	logic [COORD_BITS-1:0]      da_q;
	logic [COORD_BITS-1:0]      db_q;
	logic [COORD_BITS-1:0]      end_q;
	logic [COORD_BITS-1:0]      major_q;
	logic [COORD_BITS-1:0]      minor_q;
	logic signed [ERR_BITS-1:0] err_q;

	logic [COORD_BITS-1:0]      adx, ady;
	logic                       steep;
	logic [COORD_BITS-1:0]      a0, b0, a1, b1;
	logic [COORD_BITS-1:0]      da, db;
	logic                       neg;
	logic signed [ERR_BITS-1:0] err_init;
	logic signed [ERR_BITS-1:0] err_next;
	logic [COORD_BITS-1:0]      minor_next;
	logic                       last;

	// Pick the stepping axis and order the endpoints so the major coordinate rises.
	always_comb begin
		adx = (seg.x1 > seg.x0) ? seg.x1 - seg.x0 : seg.x0 - seg.x1;
		ady = (seg.y1 > seg.y0) ? seg.y1 - seg.y0 : seg.y0 - seg.y1;
		steep = !(ady < adx);
		if (!steep) begin
			if (seg.x0 > seg.x1) begin
				a0 = seg.x1; b0 = seg.y1; a1 = seg.x0; b1 = seg.y0;
			end else begin
				a0 = seg.x0; b0 = seg.y0; a1 = seg.x1; b1 = seg.y1;
			end
		end else begin
			if (seg.y0 > seg.y1) begin
				a0 = seg.y1; b0 = seg.x1; a1 = seg.y0; b1 = seg.x0;
			end else begin
				a0 = seg.y0; b0 = seg.x0; a1 = seg.y1; b1 = seg.x1;
			end
		end
		da = a1 - a0;
		neg = b1 < b0;
		db = neg ? b0 - b1 : b1 - b0;
		err_init = $signed({2'b00, db, 1'b0}) - $signed({3'b000, da});
	end

	// One Bresenham step per cycle.
	always_comb begin
		last = major_q == end_q;
		minor_next = minor_q;
		err_next = err_q + $signed({2'b00, db_q, 1'b0});
		if (err_q > 0) begin
			minor_next = neg_q ? minor_q - COORD_BITS'(1) : minor_q + COORD_BITS'(1);
			err_next = err_next - $signed({2'b00, da_q, 1'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steep_q <= 1'b0;
			neg_q   <= 1'b0;
			da_q    <= '0;
			db_q    <= '0;
			end_q   <= '0;
			major_q <= '0;
			minor_q <= '0;
			err_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			steep_q <= steep;
			neg_q   <= neg;
			da_q    <= da;
			db_q    <= db;
			end_q   <= a1;
			major_q <= a0;
			minor_q <= b0;
			err_q   <= err_init;
		end else if (busy_q) begin
			major_q <= major_q + COORD_BITS'(1);
			minor_q <= minor_next;
			err_q   <= err_next;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Current pixel in grid coordinates.
	always_comb begin
		pix.valid = busy_q;
		pix.last  = last;
		pix.x     = steep_q ? minor_q : major_q;
		pix.y     = steep_q ? major_q : minor_q;
	end

endmodule

// ===== rtl/line_density_accumulator.sv =====
// A segment beat walks its pixels and does one read-modify-write of the count memory per
// pixel that lies on the grid; a read beat reads the one entry at its start point.
// A clear beat sweeps the count memory one entry per cycle over all CELL_TOTAL (65536) entries.
// One beat is worked at a time; the next is taken once the result sits in the output register.
// After reset a clearing pass over all CELL_TOTAL (65536) entries runs with in_stall high.
module line_density_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [7:0]  end_x,
	input  logic [7:0]  end_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] count_value,
	output logic [1:0]  done_kind
);
	import lda_pkg::*;

	st_t                   state_q, state_nx;
	logic [ADDR_BITS-1:0]  clr_q;
	logic [1:0]            kind_q;
	logic [COORD_BITS-1:0] rd_x_q, rd_y_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] count_value_q;
	logic [1:0]            done_kind_q;

	logic                  wr_s1;
	logic [ADDR_BITS-1:0]  addr_s1;

	logic                  accept;
	logic                  out_free;
	logic                  clearing;
	logic                  walk_start;
	logic                  rd_en;
	logic [ADDR_BITS-1:0]  raddr;
	logic                  we;
	logic [ADDR_BITS-1:0]  waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic [COUNT_BITS-1:0] rdata;
	logic                  pix_hit;
	seg_t                  seg;
	pix_t                  pix;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign seg      = '{x0: start_x, y0: start_y, x1: end_x, y1: end_y};
	assign pix_hit  = pix.valid && on_grid(pix.x, pix.y);

	lda_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (walk_start),
		.seg    (seg),
		.pix    (pix)
	);

	lda_count_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_BOOT_CLEAR: begin
				if (clr_q == LAST_ADDR) state_nx = ST_IDLE;
			end
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_nx = ST_FINISH;
			end
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_CLEAR: state_nx = ST_CLEAR;
						KIND_DRAW:  state_nx = ST_WALK;
						KIND_READ:  state_nx = ST_READ;
						default:    state_nx = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				if (pix.valid && pix.last) state_nx = ST_FINISH;
			end
			ST_READ: begin
				state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		in_stall   = 1'b1;
		clearing   = 1'b0;
		walk_start = 1'b0;
		rd_en      = 1'b0;
		raddr      = cell_addr(pix.x, pix.y);
		case (state_q)
			ST_BOOT_CLEAR, ST_CLEAR: begin
				clearing = 1'b1;
			end
			ST_IDLE: begin
				in_stall   = 1'b0;
				walk_start = in_valid && (kind == KIND_DRAW);
			end
			ST_WALK: begin
				rd_en = pix_hit;
			end
			ST_READ: begin
				rd_en = on_grid(rd_x_q, rd_y_q);
				raddr = cell_addr(rd_x_q, rd_y_q);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Write port: clearing sweep, or the increment in the cycle after its read.
	always_comb begin
		we    = clearing || wr_s1;
		waddr = clearing ? clr_q : addr_s1;
		wdata = clearing ? '0 : sat_inc(rdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT_CLEAR;
			clr_q   <= '0;
			wr_s1   <= 1'b0;
		end else begin
			state_q <= state_nx;
			wr_s1   <= (state_q == ST_WALK) && pix_hit;
			if (clearing) begin
				clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + ADDR_BITS'(1);
			end
		end
	end

	// Pixel address for the pending write.
	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
	end

	// Beat capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			rd_x_q <= start_x;
			rd_y_q <= start_y;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			done_kind_q   <= kind_q;
			count_value_q <= (kind_q == KIND_READ && on_grid(rd_x_q, rd_y_q)) ?
				clip_value(rdata) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign count_value = count_value_q;
	assign done_kind   = done_kind_q;

	// The increment never collides with the clearing sweep.
	a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_s1 && clearing))
		else $error("increment write during clearing pass");

	// The walker only runs while the sequencer is in the walk state.
	a_walk_state: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> state_q == ST_WALK)
		else $error("walker active outside walk state");

	// A pending write never targets the entry being read in the same cycle.
	a_no_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_s1 && rd_en) |-> raddr != addr_s1)
		else $error("read and write of one entry overlap");

	// A result appears only out of the finish state.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result without finished beat");

endmodule
